// ----- rtl/ps2c_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ps2c_pkg;

    // Command queue toward the keyboard.
    localparam int QUEUE_DEPTH = 32;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_INITIAL_LEDS = 1'b0;
    localparam logic REG_LED_COMMAND  = 1'b1;
    localparam logic [2:0] INITIAL_LEDS_RESET = 3'd0;
    localparam logic [7:0] LED_COMMAND_RESET  = 8'd237;

    // Word destinations.
    localparam logic TGT_WINDOW   = 1'b0;
    localparam logic TGT_KEYBOARD = 1'b1;

    // Scan codes of interest (set 1).
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS_LOCK    = 8'h3A;
    localparam logic [7:0] SC_NUM_LOCK     = 8'h45;
    localparam logic [7:0] SC_SCROLL_LOCK  = 8'h46;
    localparam logic [7:0] SC_ACK          = 8'hFA;
    localparam logic [7:0] SC_RESEND       = 8'hFE;
    localparam logic [7:0] KBD_NOTHING     = 8'hFF;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;

    // Lock mask bits.
    localparam logic [2:0] LED_CAPS   = 3'b100;
    localparam logic [2:0] LED_NUM    = 3'b010;
    localparam logic [2:0] LED_SCROLL = 3'b001;

    typedef struct packed {
        logic [7:0] scan_code;
    } t_in_word;

    typedef struct packed {
        logic       target;
        logic [7:0] value;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic       vld;
        logic [7:0] ch;
    } t_char_res;

    localparam logic [7:0] PLAIN_MAP [128] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h5E, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h40, 8'h5B, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
        8'h3A, 8'h00, 8'h00, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00
    };

    localparam logic [7:0] SHIFTED_MAP [128] = '{
        8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h27, 8'h28, 8'h29, 8'h7E, 8'h3D, 8'h7E, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h60, 8'h7B, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h2B,
        8'h2A, 8'h00, 8'h00, 8'h7D, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7C, 8'h00, 8'h00
    };

    // Advances a queue pointer by a count, wrapping at the queue depth.
    // The sum stays below twice the depth, so one subtract is enough.
    function automatic logic [QPTR_W-1:0] ptr_add(input logic [QPTR_W-1:0] ptr,
                                                  input logic [QCNT_W-1:0] cnt);
        logic [QCNT_W:0] sum;
        sum = (QCNT_W+1)'(ptr) + (QCNT_W+1)'(cnt);
        if (sum >= (QCNT_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (QCNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[QPTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ps2c_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ps2c_in_if;
    logic                valid;
    logic                ready;
    ps2c_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ps2c_out_if;
    logic                valid;
    logic                ready;
    ps2c_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ps2c_char_map.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Maps a make code to a character, with letter case from shift and caps lock.
module ps2c_char_map (
    input  wire logic [7:0]          i_code,
    input  wire logic                i_shift_any,
    input  wire logic                i_caps,
    output ps2c_pkg::t_char_res      o_char
);

    logic [7:0] raw;
    logic [7:0] ch;

    always_comb begin
        raw = i_shift_any ? ps2c_pkg::SHIFTED_MAP[i_code[6:0]]
                          : ps2c_pkg::PLAIN_MAP[i_code[6:0]];
        ch  = raw;
        // Letters are lower case unless exactly one of caps lock and shift is on.
        if (raw inside {[8'h41:8'h5A]} && (i_caps == i_shift_any)) begin
            ch = raw + ps2c_pkg::CASE_OFFSET;
        end
        o_char.vld = !i_code[7] && (ch != 8'h00);
        o_char.ch  = ch;
    end

endmodule

`default_nettype wire

// ----- rtl/ps2_scancode_to_char_with_led_cmd_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Scan code set 1 translator with a keyboard LED command queue.
//
// i_scan takes one raw scan code byte per word. o_word gives result words:
// target selects the active window (character) or the keyboard (command
// byte), value carries the byte, and last marks the final word caused by
// one scan code. A scan code causes zero, one or two words.
//
// A scan code is held in the input register and is decoded into the
// two-entry result buffer once that buffer is empty or is emptied by the
// word leaving in the same cycle. Words leave one per cycle from slot 0
// while the receiver is ready; the drain rate of that buffer sets the
// throughput. An input register parts the two sides, so a new scan code
// is taken while results still wait. When the receiver stalls, the result
// buffer holds, the input register fills, and i_scan.ready falls until
// words drain.
//
// Reset (synchronous, active low) clears shift and acknowledge state, loads
// the lock mask from initial_leds and queues the LED command and the mask.
// A write to either APB register reloads the same state from the new values;
// write registers only while the block is idle.
module ps2_scancode_to_char_with_led_cmd_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ps2c_in_if.sink                              i_scan,
    ps2c_out_if.source                           o_word,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ps2c_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [ps2c_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [ps2c_pkg::APB_DATA_W-1:0] prdata,
    output      logic                            pready
);

    localparam int QPTR_W = ps2c_pkg::QPTR_W;
    localparam int QCNT_W = ps2c_pkg::QCNT_W;

    // Configuration registers.
    logic [2:0] r_init_leds, n_init_leds;
    logic [7:0] r_led_cmd, n_led_cmd;
    logic       cfg_wr;

    // Translator state.
    logic [1:0]        r_shift, n_shift;
    logic [2:0]        r_lock, n_lock;
    logic              r_ack, n_ack;
    logic [7:0]        r_pend, n_pend;
    logic [QPTR_W-1:0] r_head, n_head;
    logic [QCNT_W-1:0] r_qcnt, n_qcnt;
    logic [7:0]        r_queue [ps2c_pkg::QUEUE_DEPTH];

    // Input register.
    logic       r_in_vld;
    logic [7:0] r_in_code;

    // Result buffer: slot 0 is presented on o_word.
    ps2c_pkg::t_out_word r_slot [2];
    logic [1:0]          r_ocnt;

    logic out_pop;
    logic go;
    logic in_take;

    // Decode signals.
    ps2c_pkg::t_char_res chr;
    logic                snd;
    logic [7:0]          q_byte;
    logic                ack1;
    logic [7:0]          pend1;
    logic [QPTR_W-1:0]   head1;
    logic [QCNT_W-1:0]   cnt1;
    logic                resend;
    logic [7:0]          rs_byte;
    logic                tog;
    logic [2:0]          tog_bit;
    logic [2:0]          lock2;
    logic [QPTR_W-1:0]   tail0, tail1;
    logic                push0, push1;
    logic                second;
    ps2c_pkg::t_out_word res0, res1;
    logic [1:0]          res_n;

    // Reload of the state after reset or a configuration write.
    logic       ld;
    logic [7:0] ld_cmd;
    logic [2:0] ld_init;

    // ---------------------------------------------------------------
    // APB configuration port. Writes complete in the access phase.
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_init_leds = r_init_leds;
        n_led_cmd   = r_led_cmd;
        if (cfg_wr) begin
            case (paddr[2])
                ps2c_pkg::REG_INITIAL_LEDS: n_init_leds = pwdata[2:0];
                ps2c_pkg::REG_LED_COMMAND:  n_led_cmd   = pwdata[7:0];
                default:                    n_led_cmd   = r_led_cmd;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ps2c_pkg::REG_INITIAL_LEDS: prdata = {29'd0, r_init_leds};
            ps2c_pkg::REG_LED_COMMAND:  prdata = {24'd0, r_led_cmd};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_leds <= ps2c_pkg::INITIAL_LEDS_RESET;
            r_led_cmd   <= ps2c_pkg::LED_COMMAND_RESET;
        end else begin
            r_init_leds <= n_init_leds;
            r_led_cmd   <= n_led_cmd;
        end
    end

    assign ld      = !i_rst_n || cfg_wr;
    assign ld_cmd  = i_rst_n ? n_led_cmd : ps2c_pkg::LED_COMMAND_RESET;
    assign ld_init = i_rst_n ? n_init_leds : ps2c_pkg::INITIAL_LEDS_RESET;

    // ---------------------------------------------------------------
    // Handshakes. The held scan code is decoded once the result buffer
    // is empty, or is emptied by the word leaving in this cycle.
    // ---------------------------------------------------------------
    assign out_pop      = o_word.valid && o_word.ready;
    assign go           = r_in_vld && ((r_ocnt == 2'd0) || ((r_ocnt == 2'd1) && out_pop));
    assign i_scan.ready = !r_in_vld || go;
    assign in_take      = i_scan.valid && i_scan.ready;

    assign o_word.valid = (r_ocnt != 2'd0);
    assign o_word.data  = r_slot[0];

    // ---------------------------------------------------------------
    // Decode of the held scan code.
    // ---------------------------------------------------------------
    ps2c_char_map u_char_map (
        .i_code      (r_in_code),
        .i_shift_any (r_shift != 2'b00),
        .i_caps      (r_lock[2]),
        .o_char      (chr)
    );

    always_comb begin
        // A queued byte goes out first when no acknowledge is outstanding.
        snd    = (r_qcnt != '0) && !r_ack;
        q_byte = r_queue[r_head];
        ack1   = snd ? 1'b1 : r_ack;
        pend1  = snd ? q_byte : r_pend;
        head1  = snd ? ps2c_pkg::ptr_add(r_head, QCNT_W'(1)) : r_head;
        cnt1   = r_qcnt - QCNT_W'(snd);

        // A resend request repeats the outstanding byte, or sends the
        // no-data byte when nothing is outstanding.
        resend  = (r_in_code == ps2c_pkg::SC_RESEND);
        rs_byte = ack1 ? pend1 : ps2c_pkg::KBD_NOTHING;

        // A character and a resend never come from the same scan code.
        second = chr.vld || resend;
        res1.target = chr.vld ? ps2c_pkg::TGT_WINDOW : ps2c_pkg::TGT_KEYBOARD;
        res1.value  = chr.vld ? chr.ch : rs_byte;
        res1.last   = 1'b1;
        if (snd) begin
            res0.target = ps2c_pkg::TGT_KEYBOARD;
            res0.value  = q_byte;
            res0.last   = !second;
            res_n       = second ? 2'd2 : 2'd1;
        end else begin
            res0  = res1;
            res_n = second ? 2'd1 : 2'd0;
        end

        // Shift keys.
        n_shift = r_shift;
        case (r_in_code)
            ps2c_pkg::SC_LSHIFT_MAKE:  n_shift[0] = 1'b1;
            ps2c_pkg::SC_RSHIFT_MAKE:  n_shift[1] = 1'b1;
            ps2c_pkg::SC_LSHIFT_BREAK: n_shift[0] = 1'b0;
            ps2c_pkg::SC_RSHIFT_BREAK: n_shift[1] = 1'b0;
            default:                   n_shift    = r_shift;
        endcase

        // Lock keys toggle one bit and queue the command and the new mask.
        tog = 1'b1;
        case (r_in_code)
            ps2c_pkg::SC_CAPS_LOCK:   tog_bit = ps2c_pkg::LED_CAPS;
            ps2c_pkg::SC_NUM_LOCK:    tog_bit = ps2c_pkg::LED_NUM;
            ps2c_pkg::SC_SCROLL_LOCK: tog_bit = ps2c_pkg::LED_SCROLL;
            default: begin
                tog     = 1'b0;
                tog_bit = 3'b000;
            end
        endcase
        lock2 = r_lock ^ tog_bit;

        // Each byte is dropped on its own when the queue is full; once the
        // command byte is dropped, the mask byte is dropped as well.
        tail0 = ps2c_pkg::ptr_add(head1, cnt1);
        tail1 = ps2c_pkg::ptr_add(tail0, QCNT_W'(1));
        push0 = tog && (cnt1 < QCNT_W'(ps2c_pkg::QUEUE_DEPTH));
        push1 = tog && ((cnt1 + QCNT_W'(1)) < QCNT_W'(ps2c_pkg::QUEUE_DEPTH));

        n_lock = lock2;
        n_head = head1;
        n_qcnt = cnt1 + QCNT_W'(push0) + QCNT_W'(push1);
        n_pend = pend1;
        n_ack  = (r_in_code == ps2c_pkg::SC_ACK) ? 1'b0 : ack1;
    end

    // ---------------------------------------------------------------
    // State registers.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_shift <= 2'b00;
            r_lock  <= ld_init;
            r_ack   <= 1'b0;
            r_pend  <= 8'h00;
            r_head  <= '0;
            r_qcnt  <= QCNT_W'(2);
        end else if (go) begin
            r_shift <= n_shift;
            r_lock  <= n_lock;
            r_ack   <= n_ack;
            r_pend  <= n_pend;
            r_head  <= n_head;
            r_qcnt  <= n_qcnt;
        end
    end

    // Queue storage: the reload puts the command and the mask up front.
    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_queue[0] <= ld_cmd;
            r_queue[1] <= {5'd0, ld_init};
        end else if (go) begin
            if (push0) begin
                r_queue[tail0] <= r_led_cmd;
            end
            if (push1) begin
                r_queue[tail1] <= {5'd0, lock2};
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_code <= i_scan.data.scan_code;
        end
    end

    // Result buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= 2'd0;
        end else if (go) begin
            r_ocnt <= res_n;
        end else if (out_pop) begin
            r_ocnt <= r_ocnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_slot[0] <= res0;
            r_slot[1] <= res1;
        end else if (out_pop) begin
            r_slot[0] <= r_slot[1];
        end
    end

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    a_qcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= QCNT_W'(ps2c_pkg::QUEUE_DEPTH))
        else $error("command queue count exceeds its depth");

    a_two_words_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ocnt == 2'd2) |-> (!r_slot[0].last && r_slot[1].last))
        else $error("only the second of two buffered words may be marked last");

    a_send_sets_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && snd && !cfg_wr && (r_in_code != ps2c_pkg::SC_ACK)) |=> r_ack)
        else $error("queued byte sent without an outstanding acknowledge");

    a_decode_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |-> ((r_ocnt == 2'd0) || out_pop))
        else $error("scan code decoded while the result buffer still holds words");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the scan code translator. A directed opening script
// walks the reset state, the acknowledge and resend protocol, the shift and
// lock keys and the extreme codes. Long random runs follow under several
// register settings. Every accepted scan code is run through a predictor kept
// in this file, and every word leaving the block is compared with the oldest
// owed word.
module testbench;

    import ps2c_pkg::*;

    // Scan codes and keyboard bytes that the predictor reacts to.
    localparam logic [7:0] KEY_LSHIFT    = 8'h2A;
    localparam logic [7:0] KEY_RSHIFT    = 8'h36;
    localparam logic [7:0] KEY_LSHIFT_UP = 8'hAA;
    localparam logic [7:0] KEY_RSHIFT_UP = 8'hB6;
    localparam logic [7:0] KEY_CAPS      = 8'h3A;
    localparam logic [7:0] KEY_NUM       = 8'h45;
    localparam logic [7:0] KEY_SCROLL    = 8'h46;
    localparam logic [7:0] KBD_ACK       = 8'hFA;
    localparam logic [7:0] KBD_RESEND    = 8'hFE;
    localparam logic [7:0] KBD_IDLE_BYTE = 8'hFF;

    localparam logic [2:0] LOCK_CAPS   = 3'b100;
    localparam logic [2:0] LOCK_NUM    = 3'b010;
    localparam logic [2:0] LOCK_SCROLL = 3'b001;

    localparam logic [2:0] LEDS_AT_RESET    = 3'd0;
    localparam logic [7:0] COMMAND_AT_RESET = 8'd237;

    // A scan code waits in the input register until it is decoded, and the
    // settle time lets a code that produces no word clear the block.
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTING_COUNT = 6;

    // Character tables of the keyboard layout, unshifted and shifted.
    localparam logic [7:0] CHAR_PLAIN [128] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h5E, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h40, 8'h5B, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
        8'h3A, 8'h00, 8'h00, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00
    };

    localparam logic [7:0] CHAR_SHIFTED [128] = '{
        8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h27, 8'h28, 8'h29, 8'h7E, 8'h3D, 8'h7E, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h60, 8'h7B, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h2B,
        8'h2A, 8'h00, 8'h00, 8'h7D, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7C, 8'h00, 8'h00
    };

    // One line of the opening script. Where the answer is obvious from the
    // reset state (command byte first, acknowledge, resend with nothing
    // outstanding, extreme codes) it is written down here; other lines are
    // left to the predictor.
    typedef struct packed {
        logic [7:0] code;
        logic       typed;
        logic [1:0] count;
        t_out_word  first;
        t_out_word  second;
    } t_script_line;

    localparam t_out_word NONE = '0;

    localparam t_script_line OPENING [25] = '{
        // The LED command byte leaves on the first code after reset.
        '{8'h00, 1'b1, 2'd1, {TGT_KEYBOARD, 8'hED, 1'b1}, NONE},
        // Plain letter, no shift, no caps lock: lower case.
        '{8'h1E, 1'b1, 2'd1, {TGT_WINDOW, 8'h61, 1'b1}, NONE},
        '{KBD_ACK, 1'b1, 2'd0, NONE, NONE},
        // The LED mask goes out next; table entry 0x7F is empty.
        '{8'h7F, 1'b1, 2'd1, {TGT_KEYBOARD, 8'h00, 1'b1}, NONE},
        // Resend while a byte is outstanding repeats it.
        '{KBD_RESEND, 1'b1, 2'd1, {TGT_KEYBOARD, 8'h00, 1'b1}, NONE},
        '{KBD_ACK, 1'b1, 2'd0, NONE, NONE},
        // Resend with nothing outstanding answers with the idle byte.
        '{KBD_RESEND, 1'b1, 2'd1, {TGT_KEYBOARD, KBD_IDLE_BYTE, 1'b1}, NONE},
        '{8'hFF, 1'b1, 2'd0, NONE, NONE},
        '{KEY_LSHIFT, 1'b0, 2'd0, NONE, NONE},
        '{8'h1E, 1'b0, 2'd0, NONE, NONE},
        '{KEY_RSHIFT, 1'b0, 2'd0, NONE, NONE},
        '{KEY_LSHIFT_UP, 1'b0, 2'd0, NONE, NONE},
        '{8'h02, 1'b0, 2'd0, NONE, NONE},
        '{KEY_RSHIFT_UP, 1'b0, 2'd0, NONE, NONE},
        '{KEY_CAPS, 1'b0, 2'd0, NONE, NONE},
        // Caps lock queued a command; both words come on the next letter.
        '{8'h1E, 1'b1, 2'd2, {TGT_KEYBOARD, 8'hED, 1'b0}, {TGT_WINDOW, 8'h41, 1'b1}},
        '{KEY_LSHIFT, 1'b0, 2'd0, NONE, NONE},
        '{8'h10, 1'b0, 2'd0, NONE, NONE},
        '{KEY_LSHIFT_UP, 1'b0, 2'd0, NONE, NONE},
        '{KBD_ACK, 1'b0, 2'd0, NONE, NONE},
        '{KEY_NUM, 1'b0, 2'd0, NONE, NONE},
        '{KEY_SCROLL, 1'b0, 2'd0, NONE, NONE},
        '{KBD_ACK, 1'b0, 2'd0, NONE, NONE},
        '{KBD_RESEND, 1'b0, 2'd0, NONE, NONE},
        '{8'h73, 1'b0, 2'd0, NONE, NONE}
    };

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    ps2c_in_if  scan_if ();
    ps2c_out_if word_if ();

    ps2_scancode_to_char_with_led_cmd_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_if),
        .o_word  (word_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: the register copies and the translator state.
    logic [2:0] cfg_leds;
    logic [7:0] cfg_command;
    logic [1:0] shift_keys;
    logic [2:0] lock_mask;
    logic       ack_wait;
    logic [7:0] sent_byte;
    logic [7:0] led_fifo [$];

    // Words predicted for the code being accepted, and all words still owed.
    t_out_word  step_words [2];
    int         step_count;
    t_out_word  owed_words [$];

    int error_count;
    int codes_sent;
    int words_checked;
    int paired_codes;
    int lock_toggles;
    int dropped_bytes;
    int resend_count;
    int settings_used;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The run takes a few hundred microseconds at most even under the
    // heaviest receiver stalls; this bound leaves a wide margin.
    initial begin
        #5_000_000;
        $display("FAIL ps2_scancode_to_char_with_led_cmd_core");
        $finish;
    end

    // Reloads the translator state the way reset and register writes do.
    task automatic reload_state();
        shift_keys = 2'b00;
        lock_mask  = cfg_leds;
        ack_wait   = 1'b0;
        sent_byte  = 8'h00;
        led_fifo.delete();
        led_fifo.push_back(cfg_command);
        led_fifo.push_back({5'd0, cfg_leds});
    endtask

    // A byte offered to a full queue is lost.
    task automatic queue_led_byte(input logic [7:0] b);
        if (led_fifo.size() < QUEUE_DEPTH) begin
            led_fifo.push_back(b);
        end else begin
            dropped_bytes++;
        end
    endtask

    task automatic add_word(input logic tgt, input logic [7:0] val);
        step_words[step_count] = {tgt, val, 1'b0};
        step_count++;
    endtask

    // Works out the words caused by one scan code and updates the state.
    task automatic translate_scan(input logic [7:0] code);
        logic [7:0] ch;
        logic [2:0] flip;
        step_count = 0;

        // A queued byte goes out first unless the keyboard still owes an ack.
        if (led_fifo.size() > 0 && !ack_wait) begin
            sent_byte = led_fifo.pop_front();
            ack_wait  = 1'b1;
            add_word(TGT_KEYBOARD, sent_byte);
        end

        if (!code[7]) begin
            ch = (shift_keys == 2'b00) ? CHAR_PLAIN[code[6:0]] : CHAR_SHIFTED[code[6:0]];
            // Letters are lower case unless exactly one of caps and shift.
            if (ch >= 8'h41 && ch <= 8'h5A && (lock_mask[2] == (shift_keys != 2'b00))) begin
                ch = ch + 8'h20;
            end
            if (ch != 8'h00) begin
                add_word(TGT_WINDOW, ch);
            end
        end

        case (code)
            KEY_LSHIFT:    shift_keys[0] = 1'b1;
            KEY_RSHIFT:    shift_keys[1] = 1'b1;
            KEY_LSHIFT_UP: shift_keys[0] = 1'b0;
            KEY_RSHIFT_UP: shift_keys[1] = 1'b0;
            default: ;
        endcase

        if (code == KEY_CAPS || code == KEY_NUM || code == KEY_SCROLL) begin
            flip = (code == KEY_CAPS) ? LOCK_CAPS : (code == KEY_NUM) ? LOCK_NUM : LOCK_SCROLL;
            lock_mask = lock_mask ^ flip;
            lock_toggles++;
            queue_led_byte(cfg_command);
            queue_led_byte({5'd0, lock_mask});
        end

        if (code == KBD_ACK) begin
            ack_wait = 1'b0;
        end
        if (code == KBD_RESEND) begin
            resend_count++;
            add_word(TGT_KEYBOARD, ack_wait ? sent_byte : KBD_IDLE_BYTE);
        end

        if (step_count > 0) begin
            step_words[step_count-1].last = 1'b1;
        end
    endtask

    // Offers one scan code after an optional gap and waits for the handshake.
    // The valid line stays high when the next code follows without a gap, so
    // back-to-back codes are offered on consecutive cycles.
    task automatic send_scan(input logic [7:0] code, input int unsigned gap,
                             input logic typed, input logic [1:0] count,
                             input t_out_word first, input t_out_word second);
        @(negedge i_clk);
        if (gap > 0) begin
            scan_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        scan_if.valid          <= 1'b1;
        scan_if.data.scan_code <= code;
        do @(posedge i_clk); while (!scan_if.ready);

        codes_sent++;
        translate_scan(code);
        if (typed) begin
            // Typed answers stand in for the predicted ones, but the
            // predictor has still run so that its state moves along.
            if (count > 0) owed_words.push_back(first);
            if (count > 1) owed_words.push_back(second);
        end else begin
            for (int k = 0; k < step_count; k++) begin
                owed_words.push_back(step_words[k]);
            end
        end
        if ((typed ? int'(count) : step_count) == 2) begin
            paired_codes++;
        end
    endtask

    // Stops offering codes until every owed word has come out, then lets
    // the block settle so that a code with no word has surely finished.
    task automatic drain_block();
        @(negedge i_clk);
        scan_if.valid <= 1'b0;
        while (owed_words.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_xfer(input logic is_write, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reads a register back and compares it with the bench's copy.
    task automatic check_register(input logic idx);
        logic [APB_DATA_W-1:0] got;
        logic [APB_DATA_W-1:0] want;
        apb_xfer(1'b0, {idx, 2'b00}, '0, got);
        want = (idx == REG_INITIAL_LEDS) ? APB_DATA_W'(cfg_leds) : APB_DATA_W'(cfg_command);
        if (got !== want) begin
            $error("prdata[%0d]: expected 0x%0h, got 0x%0h", idx, want, got);
            error_count++;
        end
    endtask

    // Writes a register; any write reloads the translator state.
    task automatic write_register(input logic idx, input logic [7:0] val);
        logic [APB_DATA_W-1:0] unused;
        apb_xfer(1'b1, {idx, 2'b00}, APB_DATA_W'(val), unused);
        if (idx == REG_INITIAL_LEDS) begin
            cfg_leds = val[2:0];
        end else begin
            cfg_command = val;
        end
        reload_state();
        check_register(idx);
    endtask

    // Random traffic. Most codes model real typing: a make code followed
    // often by its break code, shift presses and releases, lock keys, and the
    // keyboard's acknowledges. The weights of lock keys and acknowledges
    // change per call, so some stretches keep the LED queue short and others
    // drive it full. The sender runs in bursts with random gaps between them.
    task automatic random_traffic(input int n);
        int unsigned lock_w;
        int unsigned ack_w;
        int unsigned r;
        int unsigned burst_left;
        int unsigned gap;
        logic        have_break;
        logic [7:0]  break_code;
        logic [7:0]  code;
        lock_w     = $urandom_range(2, 12);
        ack_w      = $urandom_range(2, 20);
        burst_left = 0;
        have_break = 1'b0;
        break_code = 8'h00;
        for (int i = 0; i < n; i++) begin
            if (have_break) begin
                code       = break_code;
                have_break = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    code = 8'($urandom_range(0, 127));
                end else if (r < 52) begin
                    case ($urandom_range(0, 3))
                        0:       code = KEY_LSHIFT;
                        1:       code = KEY_RSHIFT;
                        2:       code = KEY_LSHIFT_UP;
                        default: code = KEY_RSHIFT_UP;
                    endcase
                end else if (r < 52 + lock_w) begin
                    case ($urandom_range(0, 2))
                        0:       code = KEY_CAPS;
                        1:       code = KEY_NUM;
                        default: code = KEY_SCROLL;
                    endcase
                end else if (r < 52 + lock_w + ack_w) begin
                    code = KBD_ACK;
                end else if (r < 57 + lock_w + ack_w) begin
                    code = KBD_RESEND;
                end else begin
                    code = 8'($urandom_range(0, 255));
                end
                // Key releases follow many presses; shift keys are left
                // out since they already have explicit breaks above.
                if (!code[7] && code != KEY_LSHIFT && code != KEY_RSHIFT &&
                    $urandom_range(0, 1) == 1) begin
                    have_break = 1'b1;
                    break_code = code | 8'h80;
                end
            end

            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
            end else begin
                gap = 0;
            end
            burst_left--;
            send_scan(code, gap, 1'b0, 2'd0, NONE, NONE);
        end
    endtask

    // The receiver switches at random between stall patterns, including stretches
    // where it never stalls.
    t_rx_mode rx_mode;
    int       rx_left;
    int       rx_cycle;

    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(40, 250);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_ALWAYS:   word_if.ready <= 1'b1;
            RX_COIN:     word_if.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   word_if.ready <= ($urandom_range(0, 3) == 0);
            default:     word_if.ready <= ((rx_cycle % 7) < 4);
        endcase
    end

    // Output checker: each word taken is compared with the oldest owed one.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n === 1'b1 && word_if.valid === 1'b1 && word_if.ready === 1'b1) begin
            words_checked++;
            if (owed_words.size() == 0) begin
                $error("word 0x%0h arrived with nothing owed", word_if.data);
                error_count++;
            end else begin
                want = owed_words.pop_front();
                if (word_if.data.target !== want.target) begin
                    $error("target: expected %0d, got %0d", want.target, word_if.data.target);
                    error_count++;
                end
                if (word_if.data.value !== want.value) begin
                    $error("value: expected 0x%02h, got 0x%02h", want.value,
                           word_if.data.value);
                    error_count++;
                end
                if (word_if.data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, word_if.data.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic [2:0] leds;
        logic [7:0] command;

        rx_mode  = RX_ALWAYS;
        rx_left  = 0;
        rx_cycle = 0;
        error_count   = 0;
        codes_sent    = 0;
        words_checked = 0;
        paired_codes  = 0;
        lock_toggles  = 0;
        dropped_bytes = 0;
        resend_count  = 0;
        settings_used = 1;

        i_rst_n                = 1'b0;
        scan_if.valid          = 1'b0;
        scan_if.data.scan_code = 8'h00;
        word_if.ready          = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;

        cfg_leds    = LEDS_AT_RESET;
        cfg_command = COMMAND_AT_RESET;
        reload_state();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register reset values first; reads leave the translator alone.
        check_register(REG_INITIAL_LEDS);
        check_register(REG_LED_COMMAND);

        foreach (OPENING[k]) begin
            send_scan(OPENING[k].code, $urandom_range(0, 2), OPENING[k].typed,
                      OPENING[k].count, OPENING[k].first, OPENING[k].second);
        end

        // Random traffic under the reset settings, with one full stop in the
        // middle where the sender waits for every owed word.
        random_traffic(PHASE_ITEMS / 2);
        drain_block();
        random_traffic(PHASE_ITEMS / 2);

        // Further settings, the extremes first. Each change happens with
        // the block drained, and each write reloads the translator.
        for (int s = 0; s < SETTING_COUNT; s++) begin
            case (s)
                0:       begin leds = 3'd7; command = 8'h00; end
                1:       begin leds = 3'd0; command = 8'hFF; end
                2:       begin leds = LOCK_CAPS; command = COMMAND_AT_RESET; end
                default: begin
                    leds    = 3'($urandom_range(0, 7));
                    command = 8'($urandom_range(0, 255));
                end
            endcase
            drain_block();
            write_register(REG_INITIAL_LEDS, {5'd0, leds});
            write_register(REG_LED_COMMAND, command);
            settings_used++;
            random_traffic(PHASE_ITEMS);
        end

        drain_block();

        $display("Covered %0d scan codes under %0d register settings; %0d words checked,",
                 codes_sent, settings_used, words_checked);
        $display("%0d codes gave two words, %0d lock toggles, %0d LED bytes lost, %0d resends.",
                 paired_codes, lock_toggles, dropped_bytes, resend_count);
        if (error_count == 0 && owed_words.size() == 0) begin
            $display("PASS ps2_scancode_to_char_with_led_cmd_core");
        end else begin
            if (owed_words.size() != 0) begin
                $error("%0d words still owed at the end", owed_words.size());
            end
            $display("FAIL ps2_scancode_to_char_with_led_cmd_core");
        end
        $finish;
    end

endmodule
